@@ design/scaled_glyph_rasterizer_defines.svh @@
// Assertion macros for the glyph rasterizer checker.
`ifndef SCALED_GLYPH_RASTERIZER_DEFINES_SVH
`define SCALED_GLYPH_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SGR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgr check failed");

// Next-cycle implication, disabled in reset.
`define SGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgr check failed");

`endif

@@ design/sgr_pkg.sv @@
`default_nettype none

package sgr_pkg;

    localparam int unsigned GLYPH_COLS = 5;
    localparam int unsigned GLYPH_ROWS = 7;
    localparam int unsigned GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;

    localparam logic [0:0] REG_DOT_SCALE   = 1'd0;
    localparam logic [0:0] REG_ROTATE_MODE = 1'd1;

    localparam logic [7:0] CODE_SPACE    = 8'd32;
    localparam logic [7:0] CODE_LAST     = 8'd126;
    localparam logic [7:0] CODE_QUESTION = 8'd63;

    typedef logic [GLYPH_BITS-1:0] glyph_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic       last;
        logic [7:0] row_off;
        logic [7:0] col_off;
    } dot_req_t;

    // Dot bit for column c, row r sits at c*7+r.
    function automatic glyph_t glyph_lookup(input logic [7:0] code_in);
        logic [7:0]  code;
        logic [39:0] r;
        code = code_in;
        if (code < CODE_SPACE || code > CODE_LAST)
        begin
            code = CODE_QUESTION;
        end
        unique case (code)
            8'd33:   r = 40'h00005F0000;
            8'd34:   r = 40'h0007000700;
            8'd35:   r = 40'h147F147F14;
            8'd36:   r = 40'h242A7F2A12;
            8'd37:   r = 40'h2313086462;
            8'd38:   r = 40'h3649552250;
            8'd39:   r = 40'h0005030000;
            8'd40:   r = 40'h001C224100;
            8'd41:   r = 40'h0041221C00;
            8'd42:   r = 40'h14083E0814;
            8'd43:   r = 40'h08083E0808;
            8'd44:   r = 40'h0050300000;
            8'd45:   r = 40'h0808080808;
            8'd46:   r = 40'h0060600000;
            8'd47:   r = 40'h2010080402;
            8'd48:   r = 40'h3E5149453E;
            8'd49:   r = 40'h00427F4000;
            8'd50:   r = 40'h4261514946;
            8'd51:   r = 40'h2141454B31;
            8'd52:   r = 40'h1814127F10;
            8'd53:   r = 40'h2745454539;
            8'd54:   r = 40'h3C4A494930;
            8'd55:   r = 40'h0171090503;
            8'd56:   r = 40'h3649494936;
            8'd57:   r = 40'h064949291E;
            8'd58:   r = 40'h0036360000;
            8'd59:   r = 40'h0056360000;
            8'd60:   r = 40'h0814224100;
            8'd61:   r = 40'h1414141414;
            8'd62:   r = 40'h0041221408;
            8'd63:   r = 40'h0201510906;
            8'd64:   r = 40'h324979413E;
            8'd65:   r = 40'h7E1111117E;
            8'd66:   r = 40'h7F49494936;
            8'd67:   r = 40'h3E41414122;
            8'd68:   r = 40'h7F4141221C;
            8'd69:   r = 40'h7F49494941;
            8'd70:   r = 40'h7F09090901;
            8'd71:   r = 40'h3E4149497A;
            8'd72:   r = 40'h7F0808087F;
            8'd73:   r = 40'h00417F4100;
            8'd74:   r = 40'h2040413F01;
            8'd75:   r = 40'h7F08142241;
            8'd76:   r = 40'h7F40404040;
            8'd77:   r = 40'h7F020C027F;
            8'd78:   r = 40'h7F0408107F;
            8'd79:   r = 40'h3E4141413E;
            8'd80:   r = 40'h7F09090906;
            8'd81:   r = 40'h3E4151215E;
            8'd82:   r = 40'h7F09192946;
            8'd83:   r = 40'h4649494931;
            8'd84:   r = 40'h01017F0101;
            8'd85:   r = 40'h3F4040403F;
            8'd86:   r = 40'h1F2040201F;
            8'd87:   r = 40'h3F4038403F;
            8'd88:   r = 40'h6314081463;
            8'd89:   r = 40'h0708700807;
            8'd90:   r = 40'h6151494543;
            8'd91:   r = 40'h007F414100;
            8'd92:   r = 40'h0204081020;
            8'd93:   r = 40'h0041417F00;
            8'd94:   r = 40'h0402010204;
            8'd95:   r = 40'h4040404040;
            8'd96:   r = 40'h0001020400;
            8'd97:   r = 40'h2054545478;
            8'd98:   r = 40'h7F48444438;
            8'd99:   r = 40'h3844444420;
            8'd100:  r = 40'h384444487F;
            8'd101:  r = 40'h3854545418;
            8'd102:  r = 40'h087E090102;
            8'd103:  r = 40'h0C5252523E;
            8'd104:  r = 40'h7F08040478;
            8'd105:  r = 40'h00447D4000;
            8'd106:  r = 40'h2040443D00;
            8'd107:  r = 40'h7F10284400;
            8'd108:  r = 40'h00417F4000;
            8'd109:  r = 40'h7C04180478;
            8'd110:  r = 40'h7C08040478;
            8'd111:  r = 40'h3844444438;
            8'd112:  r = 40'h7C14141408;
            8'd113:  r = 40'h081414187C;
            8'd114:  r = 40'h7C08040408;
            8'd115:  r = 40'h4854545420;
            8'd116:  r = 40'h043F444020;
            8'd117:  r = 40'h3C4040207C;
            8'd118:  r = 40'h1C2040201C;
            8'd119:  r = 40'h3C4030403C;
            8'd120:  r = 40'h4428102844;
            8'd121:  r = 40'h0C5050503C;
            8'd122:  r = 40'h4464544C44;
            8'd123:  r = 40'h0008364100;
            default: r = 40'h0000000000;
        endcase
        return {r[6:0], r[14:8], r[22:16], r[30:24], r[38:32]};
    endfunction

endpackage

`default_nettype wire

@@ design/scaled_glyph_rasterizer.sv @@
// scaled_glyph_rasterizer
// Input channel (in_valid/in_stall) takes one word: char_code, origin_x,
// origin_y, pen_color. Output channel (out_valid/out_stall) gives one word
// per set glyph dot: square_x, square_y, square_side, square_color, and
// last_square on the final square of the character.
// Config port: cfg_write with cfg_index 0 sets dot_scale, 1 sets rotate_mode;
// write only while idle.
// Accept does the font lookup; the 35 dot positions are then scanned
// one per cycle, except while a set dot waits on a stalled output, and
// the scan stops after the last set dot. Blank glyphs or scale 0 finish
// at accept; the first square comes after the blank dots before it.
// in_stall is high while scanning; the next word is taken once the scan
// ends, even while the final square still waits in the output register.
// A stalled output holds its word and halts the scan at the next set dot.
// Reset: idle, no output pending, dot_scale 1, rotate_mode 0.
`default_nettype none

module scaled_glyph_rasterizer
    import sgr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic [7:0]  origin_x,
    input  wire logic [7:0]  origin_y,
    input  wire logic [15:0] pen_color,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       square_x,
    output logic [7:0]       square_y,
    output logic [3:0]       square_side,
    output logic [15:0]      square_color,
    output logic             last_square
);

    logic [3:0] dot_scale_reg;
    logic       rotate_mode_reg;
    logic       out_free;
    logic       busy;
    dot_req_t   req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_scale_reg   <= 4'd1;
            rotate_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DOT_SCALE:   dot_scale_reg   <= cfg_data;
                REG_ROTATE_MODE: rotate_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign in_stall = busy;

    sgr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .char_code (char_code),
        .dot_scale (dot_scale_reg),
        .out_free  (out_free),
        .busy      (busy),
        .req       (req)
    );

    sgr_dot_unit u_dot (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .pen_color    (pen_color),
        .dot_scale    (dot_scale_reg),
        .rotate_mode  (rotate_mode_reg),
        .out_stall    (out_stall),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .square_x     (square_x),
        .square_y     (square_y),
        .square_side  (square_side),
        .square_color (square_color),
        .last_square  (last_square)
    );

endmodule

`default_nettype wire

@@ design/sgr_seq.sv @@
`default_nettype none

module sgr_seq
    import sgr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] char_code,
    input  wire logic [3:0] dot_scale,
    input  wire logic       out_free,
    output logic            busy,
    output dot_req_t        req
);

    state_t     state_reg,   state_next;
    glyph_t     glyph_reg,   glyph_next;
    logic [2:0] row_reg,     row_next;
    logic [7:0] row_off_reg, row_off_next;
    logic [7:0] col_off_reg, col_off_next;
    glyph_t     loaded;
    glyph_t     shifted;
    logic [7:0] scale_ext;

    assign scale_ext = {4'd0, dot_scale};
    assign loaded    = (dot_scale == 4'd0) ? '0 : glyph_lookup(char_code);
    assign shifted   = {1'b0, glyph_reg[GLYPH_BITS-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            glyph_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            glyph_reg <= glyph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        row_off_reg <= row_off_next;
        col_off_reg <= col_off_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        glyph_next   = glyph_reg;
        row_next     = row_reg;
        row_off_next = row_off_reg;
        col_off_next = col_off_reg;
        busy         = (state_reg != ST_IDLE);
        req.load     = 1'b0;
        req.emit     = 1'b0;
        req.last     = 1'b0;
        req.row_off  = row_off_reg;
        req.col_off  = col_off_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req.load     = 1'b1;
                    glyph_next   = loaded;
                    row_next     = 3'd0;
                    row_off_next = 8'd0;
                    col_off_next = 8'd0;
                    state_next   = (loaded == '0) ? ST_IDLE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // blank dots step freely; set dots wait for the output slot
                if (!glyph_reg[0] || out_free)
                begin
                    req.emit   = glyph_reg[0];
                    req.last   = (shifted == '0);
                    glyph_next = shifted;
                    if (row_reg == 3'(GLYPH_ROWS - 1))
                    begin
                        row_next     = 3'd0;
                        row_off_next = 8'd0;
                        col_off_next = col_off_reg + scale_ext;
                    end
                    else
                    begin
                        row_next     = row_reg + 3'd1;
                        row_off_next = row_off_reg + scale_ext;
                    end
                    if (shifted == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/sgr_dot_unit.sv @@
`default_nettype none

module sgr_dot_unit
    import sgr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dot_req_t    req,
    input  wire logic [7:0]  origin_x,
    input  wire logic [7:0]  origin_y,
    input  wire logic [15:0] pen_color,
    input  wire logic [3:0]  dot_scale,
    input  wire logic        rotate_mode,
    input  wire logic        out_stall,
    output logic             out_free,
    output logic             out_valid,
    output logic [7:0]       square_x,
    output logic [7:0]       square_y,
    output logic [3:0]       square_side,
    output logic [15:0]      square_color,
    output logic             last_square
);

    logic [7:0]  ox_reg;
    logic [7:0]  oy_reg;
    logic [15:0] color_reg;
    logic        valid_reg;
    logic [7:0]  x_reg;
    logic [7:0]  y_reg;
    logic [3:0]  side_reg;
    logic [15:0] sq_color_reg;
    logic        last_reg;
    logic [7:0]  six_s;
    logic [7:0]  x_next;
    logic [7:0]  y_next;

    // 6*s = 4s + 2s
    assign six_s = {2'd0, dot_scale, 2'd0} + {3'd0, dot_scale, 1'b0};

    always_comb
    begin
        if (rotate_mode)
        begin
            x_next = ox_reg + six_s - req.row_off;
            y_next = oy_reg + req.col_off;
        end
        else
        begin
            x_next = ox_reg + req.col_off;
            y_next = oy_reg + req.row_off;
        end
    end

    assign out_free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            ox_reg    <= origin_x;
            oy_reg    <= origin_y;
            color_reg <= pen_color;
        end
        if (req.emit)
        begin
            x_reg        <= x_next;
            y_reg        <= y_next;
            side_reg     <= dot_scale;
            sq_color_reg <= color_reg;
            last_reg     <= req.last;
        end
    end

    assign out_valid    = valid_reg;
    assign square_x     = x_reg;
    assign square_y     = y_reg;
    assign square_side  = side_reg;
    assign square_color = sq_color_reg;
    assign last_square  = last_reg;

endmodule

`default_nettype wire

@@ design/sgr_checker.sv @@
`default_nettype none
`include "scaled_glyph_rasterizer_defines.svh"

module sgr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  square_x,
    input wire logic [7:0]  square_y,
    input wire logic [3:0]  square_side,
    input wire logic [15:0] square_color,
    input wire logic        last_square
);

    // a stalled square holds
    `SGR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(square_x) && $stable(square_y) && $stable(square_color) && $stable(last_square))

    // squares are never empty
    `SGR_ASSERT_NOW(a_side_nonzero, out_valid, square_side != 4'd0)

    // more squares pending means the scan is still running
    `SGR_ASSERT_NOW(a_busy_until_last, out_valid && !out_stall && !last_square, in_stall)

    // a scan starts only from an offered word
    `SGR_ASSERT_NOW(a_scan_from_word, $rose(in_stall), $past(in_valid))

endmodule

bind scaled_glyph_rasterizer sgr_checker u_sgr_checker (.*);

`default_nettype wire
